// ===== design/grap_pkg.sv =====
// ----------------------------------------------------------------------------
// grap_pkg
// Shared types and constants of the growing atlas rectangle packer.
// ----------------------------------------------------------------------------
package grap_pkg;

    localparam int COORD_BITS_DEFAULT = 16;
    localparam int PAGE_BITS_DEFAULT  = 8;

    localparam int RECT_BITS  = 12;
    localparam int PAD_BITS   = 4;
    localparam int MAX_BITS   = 15;
    localparam int OUT_COORD  = 16;
    localparam int OUT_PAGE   = 8;

    // A padded rectangle side and every fresh-page coordinate fit in this width.
    localparam int EXT_BITS   = 13;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = MAX_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PAD      = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MAX_PAGE = 1'd1;

    localparam logic [PAD_BITS-1:0] PAD_RESET      = 4'd3;
    localparam logic [MAX_BITS-1:0] MAX_PAGE_RESET = 15'd4096;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [RECT_BITS-1:0] rect_width;
        logic [RECT_BITS-1:0] rect_height;
    } item_t;

    typedef struct packed {
        logic [OUT_COORD-1:0] place_x;
        logic [OUT_COORD-1:0] place_y;
        logic [OUT_PAGE-1:0]  page_index;
        logic                 page_closed;
        logic [OUT_COORD-1:0] closed_width;
        logic [OUT_COORD-1:0] closed_height;
    } result_t;

    // Classified job: padded sizes plus the state a fresh page would hold after it.
    typedef struct packed {
        logic [EXT_BITS-1:0] w_pad;
        logic [EXT_BITS-1:0] h_pad;
        logic [PAD_BITS-1:0] pad;
        logic [EXT_BITS-1:0] fresh_cx;
        logic [EXT_BITS-1:0] fresh_cy;
        logic [EXT_BITS-1:0] fresh_pw;
        logic [EXT_BITS-1:0] fresh_ph;
    } job_t;

endpackage

// ===== design/grap_fifo.sv =====
// ----------------------------------------------------------------------------
// grap_fifo
// Small register queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module grap_fifo #(
    parameter int WIDTH = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int DEPTH    = grap_pkg::QUEUE_DEPTH;
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    slot_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg;
    logic [PTR_BITS-1:0] wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg;
    logic [PTR_BITS-1:0] rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg;
    logic [CNT_BITS-1:0] count_next;
    logic                do_push;
    logic                do_pop;

    assign full    = (count_reg == CNT_BITS'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== design/grap_front.sv =====
// ----------------------------------------------------------------------------
// grap_front
// Pads an incoming rectangle and works out its placement on a fresh page.
// ----------------------------------------------------------------------------
module grap_front (
    input  grap_pkg::item_t                    item,
    input  logic [grap_pkg::PAD_BITS-1:0]      pad,
    output grap_pkg::job_t                     job
);

    localparam int EB = grap_pkg::EXT_BITS;

    logic [EB-1:0] pad_e;
    logic [EB-1:0] w_pad;
    logic [EB-1:0] h_pad;

    assign pad_e = EB'(pad);
    assign w_pad = EB'(item.rect_width) + pad_e;
    assign h_pad = EB'(item.rect_height) + pad_e;

    // On a fresh page every side equals the pad, so the placement has a closed form.
    // With a nonzero pad the page always grows to the right first; with no pad the
    // cursor simply steps along the shorter side.
    always_comb
    begin
        job.w_pad = w_pad;
        job.h_pad = h_pad;
        job.pad   = pad;
        if (pad != '0)
        begin
            job.fresh_cx = pad_e + w_pad;
            job.fresh_cy = pad_e;
            job.fresh_pw = pad_e + w_pad;
            job.fresh_ph = pad_e + h_pad;
        end
        else if (w_pad < h_pad)
        begin
            job.fresh_cx = w_pad;
            job.fresh_cy = '0;
            job.fresh_pw = '0;
            job.fresh_ph = h_pad;
        end
        else
        begin
            job.fresh_cx = '0;
            job.fresh_cy = h_pad;
            job.fresh_pw = w_pad;
            job.fresh_ph = '0;
        end
    end

endmodule

// ===== design/grap_back.sv =====
// ----------------------------------------------------------------------------
// grap_back
// Places one padded rectangle per cycle against the live page state unless stalled.
// ----------------------------------------------------------------------------
module grap_back #(
    parameter int COORD_BITS = grap_pkg::COORD_BITS_DEFAULT,
    parameter int PAGE_BITS  = grap_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  grap_pkg::job_t                  job,
    input  logic                            job_empty,
    output logic                            job_pop,
    input  logic [grap_pkg::MAX_BITS-1:0]   max_page_size,
    output grap_pkg::result_t               result,
    output logic                            result_push,
    input  logic                            result_full
);

    localparam int C  = COORD_BITS;
    localparam int SW = (COORD_BITS + 3 > grap_pkg::MAX_BITS + 1) ?
                        COORD_BITS + 3 : grap_pkg::MAX_BITS + 1;
    localparam int PW = 2 * SW;
    localparam int OC = grap_pkg::OUT_COORD;

    logic [C-1:0]         cur_x_reg;
    logic [C-1:0]         cur_x_next;
    logic [C-1:0]         cur_y_reg;
    logic [C-1:0]         cur_y_next;
    logic [C-1:0]         page_w_reg;
    logic [C-1:0]         page_w_next;
    logic [C-1:0]         page_h_reg;
    logic [C-1:0]         page_h_next;
    logic [PAGE_BITS-1:0] page_count_reg;
    logic [PAGE_BITS-1:0] page_count_next;

    logic signed [SW-1:0] lx, ly, lw, lh, wv, hv, pv, max_s;
    logic signed [SW-1:0] dx, dy, ex, ey;
    logic signed [PW-1:0] free_area, grow_x, grow_y;
    logic                 waste;
    logic signed [SW-1:0] gx, gy, gw, gh;
    logic signed [SW-1:0] nx, ny, nw, nh;
    logic                 oversize;
    logic                 fire;
    logic [C-1:0]         px, py;

    assign fire        = !job_empty && !result_full;
    assign job_pop     = fire;
    assign result_push = fire;

    always_comb
    begin
        lx    = $signed(SW'(cur_x_reg));
        ly    = $signed(SW'(cur_y_reg));
        lw    = $signed(SW'(page_w_reg));
        lh    = $signed(SW'(page_h_reg));
        wv    = $signed(SW'(job.w_pad));
        hv    = $signed(SW'(job.h_pad));
        pv    = $signed(SW'(job.pad));
        max_s = $signed(SW'(max_page_size));

        dx = lw - lx;
        dy = lh - ly;
        ex = lx + wv - lw;
        ey = ly + hv - lh;
        free_area = PW'(dx) * PW'(dy);
        grow_x    = PW'(ex) * PW'(ly);
        grow_y    = PW'(ey) * PW'(lx);
        waste     = (grow_x > free_area) || (grow_y > free_area);

        // Too much waste: open a new strip along the shorter side of the page.
        gx = lx;
        gy = ly;
        gw = lw;
        gh = lh;
        if (waste)
        begin
            if (lw <= lh)
            begin
                gx = lw;
                gy = pv;
                gw = lw + wv;
            end
            else
            begin
                gx = pv;
                gy = lh;
                gh = lh + hv;
            end
        end

        nx = gx;
        ny = gy;
        nw = gw;
        nh = gh;
        if (gx + wv - gw < gy + hv - gh)
        begin
            nx = gx + wv;
            if (gy + hv > gh)
            begin
                nh = gy + hv;
            end
        end
        else
        begin
            ny = gy + hv;
            if (gx + wv > gw)
            begin
                nw = gx + wv;
            end
        end

        oversize = (nw > max_s) || (nh > max_s);

        if (oversize)
        begin
            cur_x_next  = C'(job.fresh_cx);
            cur_y_next  = C'(job.fresh_cy);
            page_w_next = C'(job.fresh_pw);
            page_h_next = C'(job.fresh_ph);
            page_count_next = (page_count_reg == '1) ? page_count_reg
                                                     : page_count_reg + 1'b1;
            px = C'(job.pad);
            py = C'(job.pad);
        end
        else
        begin
            cur_x_next  = nx[C-1:0];
            cur_y_next  = ny[C-1:0];
            page_w_next = nw[C-1:0];
            page_h_next = nh[C-1:0];
            page_count_next = page_count_reg;
            px = gx[C-1:0];
            py = gy[C-1:0];
        end

        result.place_x       = OC'(px);
        result.place_y       = OC'(py);
        result.page_index    = grap_pkg::OUT_PAGE'(page_count_next);
        result.page_closed   = oversize;
        result.closed_width  = oversize ? OC'(page_w_reg) : '0;
        result.closed_height = oversize ? OC'(page_h_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg      <= C'(grap_pkg::PAD_RESET);
            cur_y_reg      <= C'(grap_pkg::PAD_RESET);
            page_w_reg     <= C'(grap_pkg::PAD_RESET);
            page_h_reg     <= C'(grap_pkg::PAD_RESET);
            page_count_reg <= '0;
        end
        else if (fire)
        begin
            cur_x_reg      <= cur_x_next;
            cur_y_reg      <= cur_y_next;
            page_w_reg     <= page_w_next;
            page_h_reg     <= page_h_next;
            page_count_reg <= page_count_next;
        end
    end

endmodule

// ===== design/growing_atlas_rect_packer.sv =====
// ----------------------------------------------------------------------------
// growing_atlas_rect_packer
// Places padded rectangles into growing atlas pages and reports positions.
// ----------------------------------------------------------------------------
// The packer takes one rectangle word per clock unless the job queue is full and
// returns one result word per rectangle, in order, via the job and result queues.
// Throughput is one word per cycle without stalls, set by the placement step
// that reads and updates the page state (cursor, page size, page count). A two-word
// queue sits between the input stage and the placement step and another at the
// result side, so a stall on either side is absorbed until the queues fill. Write
// pad and max_page_size only while no words are in flight.
module growing_atlas_rect_packer #(
    parameter int COORD_BITS = grap_pkg::COORD_BITS_DEFAULT,
    parameter int PAGE_BITS  = grap_pkg::PAGE_BITS_DEFAULT
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  push,
    input  grap_pkg::item_t                       item,
    output logic                                  full,
    input  logic                                  pop,
    output grap_pkg::result_t                     result,
    output logic                                  empty,
    input  logic                                  cfg_we,
    input  logic [grap_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [grap_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int JOB_BITS    = $bits(grap_pkg::job_t);
    localparam int RESULT_BITS = $bits(grap_pkg::result_t);

    logic [grap_pkg::PAD_BITS-1:0] pad_reg;
    logic [grap_pkg::MAX_BITS-1:0] max_page_size_reg;

    grap_pkg::job_t    front_job;
    grap_pkg::job_t    back_job;
    grap_pkg::result_t back_result;
    logic              job_empty;
    logic              job_pop;
    logic              result_push;
    logic              result_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_reg           <= grap_pkg::PAD_RESET;
            max_page_size_reg <= grap_pkg::MAX_PAGE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                grap_pkg::REG_PAD:
                begin
                    pad_reg <= cfg_data[grap_pkg::PAD_BITS-1:0];
                end
                grap_pkg::REG_MAX_PAGE:
                begin
                    max_page_size_reg <= cfg_data[grap_pkg::MAX_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    grap_front u_front (
        .item (item),
        .pad  (pad_reg),
        .job  (front_job)
    );

    grap_fifo #(
        .WIDTH (JOB_BITS)
    ) u_job_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (front_job),
        .full  (full),
        .pop   (job_pop),
        .rdata (back_job),
        .empty (job_empty)
    );

    grap_back #(
        .COORD_BITS (COORD_BITS),
        .PAGE_BITS  (PAGE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job           (back_job),
        .job_empty     (job_empty),
        .job_pop       (job_pop),
        .max_page_size (max_page_size_reg),
        .result        (back_result),
        .result_push   (result_push),
        .result_full   (result_full)
    );

    grap_fifo #(
        .WIDTH (RESULT_BITS)
    ) u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (result_push),
        .wdata (back_result),
        .full  (result_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the growing atlas rectangle packer. A directed table
// covers reset state, size extremes and register extremes, then random phases
// under several pad and page-size settings place rectangles while both queue
// sides stall at random, save in the saturating page counter phase. Every result
// word is checked against an in-bench model of the cursor, page growth, page close and page counter.
// ----------------------------------------------------------------------------
module tb;

    import grap_pkg::*;

    localparam int ROW_ITEM = 0;
    localparam int ROW_REG  = 1;
    localparam int IDLE_PCT = 16;

    typedef struct {
        int                        kind;
        item_t                     rect;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
        bit                        golden;
        result_t                   want;
    } row_t;

    logic                      clk;
    logic                      rst_n     = 1'b0;
    logic                      push      = 1'b0;
    item_t                     item      = '0;
    logic                      full;
    logic                      pop       = 1'b0;
    result_t                   result;
    logic                      empty;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    // Model state, mirroring what the packer holds after reset.
    logic [PAD_BITS-1:0]  pad_r      = PAD_RESET;
    logic [MAX_BITS-1:0]  max_page_r = MAX_PAGE_RESET;
    logic [OUT_COORD-1:0] cur_x      = OUT_COORD'(PAD_RESET);
    logic [OUT_COORD-1:0] cur_y      = OUT_COORD'(PAD_RESET);
    logic [OUT_COORD-1:0] pg_w       = OUT_COORD'(PAD_RESET);
    logic [OUT_COORD-1:0] pg_h       = OUT_COORD'(PAD_RESET);
    logic [OUT_PAGE-1:0]  pg_count   = '0;

    result_t pending_places[$];
    row_t    plan[$];

    bit steady       = 1'b0;
    int errors       = 0;
    int rects_sent   = 0;
    int words_seen   = 0;
    int closes_seen  = 0;
    int reg_writes   = 0;
    int top_page     = 0;

    growing_atlas_rect_packer u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .pop       (pop),
        .result    (result),
        .empty     (empty),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // One placement attempt on the page given by the cursor and page size.
    function automatic void fit_rect(inout longint cx, inout longint cy,
                                     inout longint pw, inout longint ph,
                                     input longint rw, input longint rh,
                                     output longint px, output longint py);
        longint padv;
        longint free_area;
        padv = longint'(pad_r);
        rw += padv;
        rh += padv;
        free_area = (pw - cx) * (ph - cy);
        // Too much waste: start a new strip along the shorter side.
        if ((cx + rw - pw) * cy > free_area || (cy + rh - ph) * cx > free_area)
        begin
            if (pw <= ph)
            begin
                cx = pw;
                cy = padv;
                pw += rw;
            end
            else
            begin
                cx = padv;
                cy = ph;
                ph += rh;
            end
        end
        px = cx;
        py = cy;
        if (cx + rw - pw < cy + rh - ph)
        begin
            cx += rw;
            if (cy + rh > ph) ph = cy + rh;
        end
        else
        begin
            cy += rh;
            if (cx + rw > pw) pw = cx + rw;
        end
    endfunction

    function automatic result_t place_rect(item_t rect);
        result_t r;
        longint  cx, cy, pw, ph, px, py, limit;
        logic [OUT_COORD-1:0] old_w, old_h;
        bit closed;
        old_w  = pg_w;
        old_h  = pg_h;
        closed = 1'b0;
        limit  = longint'(max_page_r);
        cx = longint'(cur_x);
        cy = longint'(cur_y);
        pw = longint'(pg_w);
        ph = longint'(pg_h);
        fit_rect(cx, cy, pw, ph, longint'(rect.rect_width), longint'(rect.rect_height),
                 px, py);
        // Page would outgrow the limit: close it and place again on a fresh page.
        if (pw > limit || ph > limit)
        begin
            closed = 1'b1;
            if (pg_count != '1) pg_count = pg_count + 1'b1;
            cx = longint'(pad_r);
            cy = cx;
            pw = cx;
            ph = cx;
            fit_rect(cx, cy, pw, ph, longint'(rect.rect_width),
                     longint'(rect.rect_height), px, py);
        end
        cur_x = cx[OUT_COORD-1:0];
        cur_y = cy[OUT_COORD-1:0];
        pg_w  = pw[OUT_COORD-1:0];
        pg_h  = ph[OUT_COORD-1:0];
        r.place_x       = px[OUT_COORD-1:0];
        r.place_y       = py[OUT_COORD-1:0];
        r.page_index    = pg_count;
        r.page_closed   = closed;
        r.closed_width  = closed ? old_w : '0;
        r.closed_height = closed ? old_h : '0;
        return r;
    endfunction

    function automatic row_t item_row(int w, int h);
        row_t r;
        r = '{kind: ROW_ITEM, rect: '0, index: '0, data: '0, golden: 1'b0, want: '0};
        r.rect.rect_width  = RECT_BITS'(w);
        r.rect.rect_height = RECT_BITS'(h);
        return r;
    endfunction

    function automatic row_t reg_row(logic [CFG_INDEX_BITS-1:0] idx, int value);
        row_t r;
        r = '{kind: ROW_REG, rect: '0, index: idx, data: CFG_DATA_BITS'(value),
              golden: 1'b0, want: '0};
        return r;
    endfunction

    function automatic void add_row(row_t r);
        plan.insert(plan.size(), r);
    endfunction

    function automatic item_t random_rect();
        item_t r;
        int    pick;
        pick = $urandom_range(99);
        if (pick < 60)
        begin
            r.rect_width  = RECT_BITS'($urandom_range(63));
            r.rect_height = RECT_BITS'($urandom_range(63));
        end
        else if (pick < 85)
        begin
            r.rect_width  = RECT_BITS'($urandom_range(511));
            r.rect_height = RECT_BITS'($urandom_range(511));
        end
        else if (pick < 95)
        begin
            r.rect_width  = RECT_BITS'($urandom_range(4095));
            r.rect_height = RECT_BITS'($urandom_range(4095));
        end
        else
        begin
            r.rect_width  = $urandom_range(1) ? '1 : '0;
            r.rect_height = $urandom_range(1) ? '1 : '0;
        end
        return r;
    endfunction

    function automatic bit take_break();
        return !steady && ($urandom_range(99) < IDLE_PCT);
    endfunction

    task automatic flag_mismatch(string msg);
        errors++;
        $display("MISMATCH @%0t word %0d: %s", $realtime, words_seen, msg);
    endtask

    task automatic check_field(string name, logic [OUT_COORD-1:0] got,
                               logic [OUT_COORD-1:0] want);
        if (got !== want) flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // Push stays high from one word to the next unless a break is taken.
    task automatic send_rect(item_t rect, bit golden, result_t want);
        result_t predicted;
        while (take_break())
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= rect;
        @(posedge clk);
        while (full) @(posedge clk);
        predicted = place_rect(rect);
        pending_places.insert(pending_places.size(), golden ? want : predicted);
        rects_sent++;
    endtask

    task automatic drain();
        push <= 1'b0;
        while (pending_places.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_PAD)
            pad_r = value[PAD_BITS-1:0];
        else if (idx == REG_MAX_PAGE)
            max_page_r = value[MAX_BITS-1:0];
        reg_writes++;
    endtask

    // Result side: random back-pressure, each popped word checked in order.
    initial
    begin
        result_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            pop <= !take_break();
            @(posedge clk);
            if (pop && !empty)
            begin
                words_seen++;
                if (result.page_closed) closes_seen++;
                if (int'(result.page_index) > top_page) top_page = int'(result.page_index);
                if (pending_places.size() == 0)
                    flag_mismatch("result word with nothing expected");
                else
                begin
                    want = pending_places.pop_front();
                    check_field("place_x", result.place_x, want.place_x);
                    check_field("place_y", result.place_y, want.place_y);
                    check_field("page_index", OUT_COORD'(result.page_index),
                                OUT_COORD'(want.page_index));
                    check_field("page_closed", OUT_COORD'(result.page_closed),
                                OUT_COORD'(want.page_closed));
                    check_field("closed_width", result.closed_width, want.closed_width);
                    check_field("closed_height", result.closed_height, want.closed_height);
                end
            end
        end
    end

    initial
    begin
        row_t    row;
        result_t first_want;
        int      pad_val;
        int      max_val;
        int      count;
        int      waited;

        // Fresh page after reset: the first rectangle lands at the padded origin.
        row = item_row(0, 0);
        row.golden = 1'b1;
        first_want = '0;
        first_want.place_x = OUT_COORD'(PAD_RESET);
        first_want.place_y = OUT_COORD'(PAD_RESET);
        row.want = first_want;
        add_row(row);
        add_row(item_row(4095, 4095));
        add_row(item_row(4095, 0));
        add_row(item_row(0, 4095));
        add_row(item_row(1, 1));
        add_row(item_row(2730, 1365));
        // Upper data bits are not part of the pad register.
        add_row(reg_row(REG_PAD, 'h7FF0));
        add_row(item_row(0, 0));
        add_row(item_row(0, 0));
        add_row(item_row(9, 3));
        add_row(reg_row(REG_PAD, 'h000F));
        // A zero limit closes the page on every rectangle.
        add_row(reg_row(REG_MAX_PAGE, 0));
        add_row(item_row(5, 5));
        add_row(item_row(4095, 4095));
        add_row(item_row(0, 0));
        add_row(reg_row(REG_MAX_PAGE, 1));
        add_row(item_row(0, 0));
        add_row(item_row(1365, 2730));
        add_row(reg_row(REG_MAX_PAGE, 'h7FFF));
        add_row(item_row(4095, 4095));
        add_row(item_row(4095, 4095));
        add_row(item_row(4095, 4095));
        add_row(item_row(4095, 4095));
        add_row(reg_row(REG_MAX_PAGE, 16384));
        add_row(item_row(4095, 4095));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].index, plan[i].data);
            else
                send_rect(plan[i].rect, plan[i].golden, plan[i].want);
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    pad_val = 0;
                    max_val = 'h7FFF;
                    count   = 150;
                end
                1:
                begin
                    pad_val = 15;
                    max_val = 1;
                    count   = 60;
                end
                2:
                begin
                    pad_val = $urandom_range(15);
                    max_val = 0;
                    count   = 300;
                end
                3:
                begin
                    pad_val = $urandom_range(15);
                    max_val = 16384;
                    count   = 180;
                end
                4:
                begin
                    pad_val = $urandom_range(15);
                    max_val = $urandom_range(2048, 64);
                    count   = 200;
                end
                default:
                begin
                    pad_val = 3;
                    max_val = 4096;
                    count   = 200;
                end
            endcase
            write_reg(REG_PAD, {(CFG_DATA_BITS-PAD_BITS)'($urandom_range(2047)),
                                pad_val[PAD_BITS-1:0]});
            write_reg(REG_MAX_PAGE, CFG_DATA_BITS'(max_val));
            // The saturating page counter phase runs with no stalls on either side.
            steady = (phase == 2);
            repeat (count) send_rect(random_rect(), 1'b0, '0);
        end
        steady = 1'b0;

        push <= 1'b0;
        waited = 0;
        while (pending_places.size() != 0 && waited < 100_000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (pending_places.size() != 0)
            flag_mismatch($sformatf("%0d expected words never arrived", pending_places.size()));

        $display("Placed %0d rectangles over %0d register writes; %0d words checked.",
                 rects_sent, reg_writes, words_seen);
        $display("Saw %0d page closes, highest page index %0d; %0d mismatches.",
                 closes_seen, top_page, errors);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
